FILE: sv/assert_macros.svh
// assertion macros used by the ring queue datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RMPQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RMPQ_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define RMPQ_ASSERT(name, clk, rst_n, prop)
`define RMPQ_ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

FILE: sv/rmpq_pkg.sv
// shared constants and controller/datapath interface types of the ring queue
`default_nettype none
package rmpq_pkg;

  localparam int DEPTH  = 128;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CAP_W  = 8;
  localparam int OCC_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  // input command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_OVERFLOW  = 2'd1,
    RES_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic latch_in;
    logic start_scan;
    logic scan_step;
    logic enq_write;
    logic set_ovf;
    logic set_udf;
    logic take_min;
    logic clear_all;
    logic head_adv;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic tail_back;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_deq;
    logic is_empty;
    logic is_full;
    logic single;
    logic best_at_head;
    logic scan_done;
    logic shift_at_tail;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/ring_min_priority_queue.sv
// top level of the ring buffer minimum priority queue
//
// input channel: in_valid_i / in_stall_o with in_cmd_i (enqueue or dequeue)
//   and in_value_i; an item is taken when valid is high and stall is low
// output channel: out_valid_o / out_stall_i with status, removed value and
//   occupancy after the operation; exactly one result per item
// config: cfg_we_i writes cfg_data_i as the ring capacity and empties the queue
// enqueue, overflow and underflow are decided in the decode state; a dequeue
//   scans all entries held, then advances the head or empties the queue
//   when the minimum is at the head or is the only entry, and otherwise moves
//   the later entries down, if any, and steps the tail back
//   the scan reads one entry per cycle through the single memory read port,
//   and each shift step is one read then one write of the entry memory
// one item is in work at a time; the next item is taken as soon as the
//   result is in the output register, even while that result is stalled
// a stalled result holds in the output register; a new result waits in the
//   controller until the old one has been taken
// reset: empty queue, capacity 128, no result pending; the entry memory is
//   not cleared, only written entries are ever read
`default_nettype none
module ring_min_priority_queue import rmpq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     in_cmd_i,
  input  logic signed [DATA_W-1:0] in_value_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               out_status_o,
  output logic signed [DATA_W-1:0] out_removed_value_o,
  output logic [OCC_W-1:0]         out_occupancy_o,
  // capacity register
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencing: decode, scan, shift, result load
  rmpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // entry memory, ring pointers and result register
  rmpq_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .stat_o              (dp_stat),
    .in_cmd_i            (in_cmd_i),
    .in_value_i          (in_value_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_o        (out_status_o),
    .out_removed_value_o (out_removed_value_o),
    .out_occupancy_o     (out_occupancy_o)
  );

endmodule
`default_nettype wire

FILE: sv/rmpq_datapath.sv
// ring queue datapath: entry memory, pointers, min scan, shift and result register
`default_nettype none
`include "assert_macros.svh"
module rmpq_datapath import rmpq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic                     in_cmd_i,
  input  logic signed [DATA_W-1:0] in_value_i,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               out_status_o,
  output logic signed [DATA_W-1:0] out_removed_value_o,
  output logic [OCC_W-1:0]         out_occupancy_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]  cap_q;
  logic [CAP_W-1:0]  cap_eff;
  logic [IDX_W-1:0]  head_q, tail_q;
  logic              empty_q;
  logic              cmd_q;
  logic signed [DATA_W-1:0] val_q;

  logic [IDX_W-1:0]  scan_ptr_q, cmp_idx_q, best_idx_q, shift_ptr_q;
  logic              issue_done_q, cmp_vld_q, first_q;
  logic signed [DATA_W-1:0] best_val_q;
  logic signed [DATA_W-1:0] rdata_q;

  status_e           status_q;
  logic signed [DATA_W-1:0] rem_q;

  logic              out_vld_q;
  status_e           out_status_q;
  logic signed [DATA_W-1:0] out_rem_q;
  logic [OCC_W-1:0]  out_occ_q;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [CAP_W:0]    occ_w;
  logic [IDX_W-1:0]  tail_nxt;

  function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i,
                                           input logic [CAP_W-1:0] c);
    logic [CAP_W:0] inc;
    inc = (CAP_W+1)'(i) + (CAP_W+1)'(1);
    if (inc >= (CAP_W+1)'(c)) return '0;
    return inc[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] prv(input logic [IDX_W-1:0] i,
                                           input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] cm1;
    cm1 = c - CAP_W'(1);
    if (i == '0) return cm1[IDX_W-1:0];
    return i - IDX_W'(1);
  endfunction

  // 0 acts as 1, anything above the depth acts as the depth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_q > CAP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign tail_nxt = nxt(tail_q, cap_eff);

  always_comb begin
    if (empty_q) begin
      occ_w = '0;
    end else if (tail_q >= head_q) begin
      occ_w = (CAP_W+1)'(tail_q) - (CAP_W+1)'(head_q) + (CAP_W+1)'(1);
    end else begin
      occ_w = (CAP_W+1)'(tail_q) + (CAP_W+1)'(cap_eff) - (CAP_W+1)'(head_q)
              + (CAP_W+1)'(1);
    end
  end

  // memory port control
  assign rd_en   = (cmd_i.scan_step && !issue_done_q) || cmd_i.shift_rd;
  assign rd_addr = cmd_i.shift_rd ? nxt(shift_ptr_q, cap_eff) : scan_ptr_q;
  assign wr_en   = cmd_i.enq_write || cmd_i.shift_wr;
  assign wr_addr = cmd_i.enq_write ? (empty_q ? '0 : tail_nxt) : shift_ptr_q;
  assign wr_data = cmd_i.enq_write ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // ring pointers and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (cfg_we_i) begin
      cap_q   <= cfg_data_i;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      if (cmd_i.enq_write) begin
        if (empty_q) begin
          head_q  <= '0;
          tail_q  <= '0;
          empty_q <= 1'b0;
        end else begin
          tail_q <= tail_nxt;
        end
      end
      if (cmd_i.clear_all) begin
        head_q  <= '0;
        tail_q  <= '0;
        empty_q <= 1'b1;
      end
      if (cmd_i.head_adv) begin
        head_q <= nxt(head_q, cap_eff);
      end
      if (cmd_i.tail_back) begin
        tail_q <= prv(tail_q, cap_eff);
      end
    end
  end

  // scan issue and compare pipeline, shift pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_ptr_q   <= '0;
      issue_done_q <= 1'b1;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      first_q      <= 1'b1;
      best_idx_q   <= '0;
      shift_ptr_q  <= '0;
    end else begin
      if (cmd_i.start_scan) begin
        scan_ptr_q   <= head_q;
        issue_done_q <= 1'b0;
        cmp_vld_q    <= 1'b0;
        first_q      <= 1'b1;
      end else if (cmd_i.scan_step) begin
        cmp_vld_q <= !issue_done_q;
        if (!issue_done_q) begin
          cmp_idx_q    <= scan_ptr_q;
          scan_ptr_q   <= nxt(scan_ptr_q, cap_eff);
          issue_done_q <= (scan_ptr_q == tail_q);
        end
        if (cmp_vld_q) begin
          first_q <= 1'b0;
          if (first_q || (rdata_q < best_val_q)) begin
            best_idx_q <= cmp_idx_q;
          end
        end
      end
      if (cmd_i.shift_init) begin
        shift_ptr_q <= best_idx_q;
      end else if (cmd_i.shift_wr) begin
        shift_ptr_q <= nxt(shift_ptr_q, cap_eff);
      end
    end
  end

  // first of equal values wins: strict less-than
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && cmp_vld_q && (first_q || (rdata_q < best_val_q))) begin
      best_val_q <= rdata_q;
    end
    if (cmd_i.latch_in) begin
      val_q <= in_value_i;
    end
  end

  // per-item status, latched command and removed value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= CMD_ENQ;
      status_q <= RES_OK;
      rem_q    <= '0;
    end else begin
      if (cmd_i.latch_in) begin
        cmd_q    <= in_cmd_i;
        status_q <= RES_OK;
        rem_q    <= '0;
      end
      if (cmd_i.set_ovf) begin
        status_q <= RES_OVERFLOW;
      end
      if (cmd_i.set_udf) begin
        status_q <= RES_UNDERFLOW;
      end
      if (cmd_i.take_min) begin
        rem_q <= best_val_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_status_q <= RES_OK;
      out_rem_q    <= '0;
      out_occ_q    <= '0;
    end else if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_rem_q    <= rem_q;
      out_occ_q    <= occ_w[OCC_W-1:0];
    end
  end

  assign out_valid_o         = out_vld_q;
  assign out_status_o        = out_status_q;
  assign out_removed_value_o = out_rem_q;
  assign out_occupancy_o     = out_occ_q;

  assign stat_o.cmd_deq       = (cmd_q == CMD_DEQ);
  assign stat_o.is_empty      = empty_q;
  assign stat_o.is_full       = (tail_nxt == head_q);
  assign stat_o.single        = (head_q == tail_q);
  assign stat_o.best_at_head  = (best_idx_q == head_q);
  assign stat_o.scan_done     = issue_done_q && !cmp_vld_q;
  assign stat_o.shift_at_tail = (shift_ptr_q == tail_q);
  assign stat_o.out_busy      = out_vld_q && out_stall_i;

  `RMPQ_ASSERT_NEVER(a_no_read_write_same_cycle, clk_i, rst_ni, rd_en && wr_en)
  `RMPQ_ASSERT(a_empty_ptrs_home, clk_i, rst_ni, empty_q |-> (head_q == '0 && tail_q == '0))
  `RMPQ_ASSERT(a_error_no_value, clk_i, rst_ni, (out_vld_q && out_status_q != RES_OK) |-> (out_rem_q == '0))

endmodule
`default_nettype wire

FILE: sv/rmpq_ctrl.sv
// ring queue controller state machine
`default_nettype none
module rmpq_ctrl import rmpq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_SCAN     = 6'b000100,
    S_SHIFT_RD = 6'b001000,
    S_SHIFT_WR = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat_i.cmd_deq) begin
          if (stat_i.is_empty || !stat_i.is_full) begin
            cmd_o.enq_write = 1'b1;
          end else begin
            cmd_o.set_ovf = 1'b1;
          end
          state_d = S_DONE;
        end else if (stat_i.is_empty) begin
          cmd_o.set_udf = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.start_scan = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.take_min = 1'b1;
          if (stat_i.single) begin
            cmd_o.clear_all = 1'b1;
            state_d         = S_DONE;
          end else if (stat_i.best_at_head) begin
            cmd_o.head_adv = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.shift_init = 1'b1;
            state_d          = S_SHIFT_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.shift_at_tail) begin
          cmd_o.tail_back = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// testbench of the ring minimum priority queue, checked item by item against a predictor
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rmpq_pkg::*;

  // a gap this long with no item moving on either side means the block hangs
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_LEN       = 300;
  localparam int REPORT_LINES   = 40;

  typedef struct {
    logic                     cmd;
    logic signed [DATA_W-1:0] value;
  } queue_op_t;

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] removed;
    logic [OCC_W-1:0]         occupancy;
  } queue_res_t;

  // clock, reset and block ports, all known from time zero
  logic                     clk_i               = 1'b0;
  logic                     rst_ni              = 1'b0;
  logic                     in_valid_i          = 1'b0;
  logic                     in_stall_o;
  logic                     in_cmd_i            = CMD_ENQ;
  logic signed [DATA_W-1:0] in_value_i          = '0;
  logic                     out_valid_o;
  logic                     out_stall_i         = 1'b0;
  logic [1:0]               out_status_o;
  logic signed [DATA_W-1:0] out_removed_value_o;
  logic [OCC_W-1:0]         out_occupancy_o;
  logic                     cfg_we_i            = 1'b0;
  logic [CAP_W-1:0]         cfg_data_i          = CAP_RESET;

  // items waiting to be offered, and results owed by the block in order
  queue_op_t  op_backlog[$];
  queue_res_t result_fifo[$];

  // shadow copy of the ring: slots, head, tail, empty flag and capacity
  logic signed [DATA_W-1:0] ring_slots [DEPTH];
  int                       ring_head;
  int                       ring_tail;
  bit                       ring_empty;
  logic [CAP_W-1:0]         ring_cap;

  // traffic shaping shared by the initial block, driver and receiver
  int  idle_pct    = 19;
  bit  hold_go     = 1'b0;
  bit  hold_over   = 1'b0;
  int  hold_cnt    = 0;
  bit  in_took     = 1'b0;
  int  idle_cycles = 0;
  int  mismatch_count = 0;

  ring_min_priority_queue dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_cmd_i            (in_cmd_i),
    .in_value_i          (in_value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_o        (out_status_o),
    .out_removed_value_o (out_removed_value_o),
    .out_occupancy_o     (out_occupancy_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ring index arithmetic over the capacity in use
  function automatic int next_slot(int i, int c);
    return (i + 1 >= c) ? 0 : i + 1;
  endfunction

  function automatic int prev_slot(int i, int c);
    return (i == 0 || i > c) ? c - 1 : i - 1;
  endfunction

  // any capacity write empties the ring
  function automatic void ring_clear(logic [CAP_W-1:0] cap);
    ring_cap   = cap;
    ring_head  = 0;
    ring_tail  = 0;
    ring_empty = 1'b1;
  endfunction

  // one enqueue or dequeue on the shadow ring, giving the result it owes
  function automatic queue_res_t ring_op(logic op, logic signed [DATA_W-1:0] val);
    queue_res_t r;
    int c;
    int i;
    int best;
    int stop;
    // zero acts as one slot, anything past the array as the whole array
    if (ring_cap == 0) c = 1;
    else if (ring_cap > DEPTH) c = DEPTH;
    else c = int'(ring_cap);
    r.status  = RES_OK;
    r.removed = '0;
    if (op == CMD_ENQ) begin
      if (ring_empty) begin
        // first entry always lands in slot 0
        ring_head     = 0;
        ring_tail     = 0;
        ring_slots[0] = val;
        ring_empty    = 1'b0;
      end else if (next_slot(ring_tail, c) == ring_head) begin
        r.status = RES_OVERFLOW;
      end else begin
        ring_tail             = next_slot(ring_tail, c);
        ring_slots[ring_tail] = val;
      end
    end else if (ring_empty) begin
      r.status = RES_UNDERFLOW;
    end else if (ring_head == ring_tail) begin
      // last entry leaves, ring returns to its empty layout
      r.removed  = ring_slots[ring_head];
      ring_head  = 0;
      ring_tail  = 0;
      ring_empty = 1'b1;
    end else begin
      // strict compare keeps the first of equal minima
      best = ring_head;
      stop = next_slot(ring_tail, c);
      i    = next_slot(ring_head, c);
      while (i != stop) begin
        if (ring_slots[i] < ring_slots[best]) best = i;
        i = next_slot(i, c);
      end
      r.removed = ring_slots[best];
      if (best == ring_head) begin
        ring_head = next_slot(ring_head, c);
      end else begin
        // close the gap by pulling later entries down, tail may wrap back
        i = best;
        while (i != ring_tail) begin
          ring_slots[i] = ring_slots[next_slot(i, c)];
          i = next_slot(i, c);
        end
        ring_tail = prev_slot(ring_tail, c);
      end
    end
    r.occupancy = ring_empty ? '0 : OCC_W'(((ring_tail + c - ring_head) % c) + 1);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < REPORT_LINES) $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // driver: new item on the falling edge once the last one was taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (op_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_cmd_i   <= op_backlog[0].cmd;
        in_value_i <= op_backlog[0].value;
        void'(op_backlog.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or one long hold counted here on request
  always @(negedge clk_i) begin
    if (hold_go && !hold_over) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN - 1) hold_over <= 1'b1;
    end else if (!hold_go) begin
      hold_cnt    <= 0;
      hold_over   <= 1'b0;
      out_stall_i <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // monitor: predicts on every accepted item, checks every accepted result
  always @(posedge clk_i) begin : monitor
    queue_res_t want;
    bit in_fire;
    bit out_fire;
    in_fire  = in_valid_i && !in_stall_o;
    out_fire = out_valid_o && !out_stall_i;
    if (!rst_ni) begin
      ring_clear(CAP_RESET);
      in_took <= 1'b0;
    end else begin
      if (cfg_we_i) ring_clear(cfg_data_i);
      if (in_fire) result_fifo.push_back(ring_op(in_cmd_i, in_value_i));
      in_took <= in_fire;
      if (out_fire) begin
        if (result_fifo.size() == 0) begin
          report_mismatch($sformatf("result with none owed: status %0d value %0d occ %0d",
                                    out_status_o, out_removed_value_o, out_occupancy_o));
        end else begin
          want = result_fifo.pop_front();
          if (out_status_o !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      out_status_o, want.status));
          if (out_removed_value_o !== want.removed)
            report_mismatch($sformatf("removed value %0d, predicted %0d",
                                      out_removed_value_o, want.removed));
          if (out_occupancy_o !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, predicted %0d",
                                      out_occupancy_o, want.occupancy));
        end
      end
      // watchdog on cycles with nothing moving
      if (in_fire || out_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic push_op(logic op, logic signed [DATA_W-1:0] v);
    queue_op_t q;
    q.cmd   = op;
    q.value = v;
    op_backlog.push_back(q);
  endtask

  // wait until the block has nothing in work and nothing owed
  task automatic drain();
    while (op_backlog.size() != 0 || in_valid_i || result_fifo.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // capacity writes happen only once drained
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(negedge clk_i);
    cfg_data_i <= cap;
    cfg_we_i   <= 1'b1;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // full-range noise, clusters of small values for ties, and the extremes
  function automatic logic signed [DATA_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return DATA_W'($urandom);
    if (pick < 70) return DATA_W'(int'($urandom_range(0, 8)) - 4);
    if (pick < 80) begin
      case ($urandom_range(0, 3))
        0:       return DATA_W'(32'h7fff_ffff);
        1:       return DATA_W'(32'h8000_0000);
        2:       return '0;
        default: return '1;
      endcase
    end
    return DATA_W'(int'($urandom_range(0, 2000)) - 1000);
  endfunction

  initial begin
    int phase_len [8];
    int phase_cap [8];
    int p;
    int k;
    int pct;

    phase_len = '{260, 80, 80, 100, 120, 60, 100, 100};
    phase_cap = '{128, 1, 2, 7, 255, 0, -1, 128};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset capacity: underflow, extremes, ties, minimum in the middle and at the tail
    push_op(CMD_DEQ, DATA_W'($urandom));
    push_op(CMD_ENQ, DATA_W'(32'h7fff_ffff));
    push_op(CMD_ENQ, DATA_W'(32'h8000_0000));
    push_op(CMD_ENQ, 5);
    push_op(CMD_ENQ, 5);
    push_op(CMD_DEQ, DATA_W'($urandom));
    push_op(CMD_DEQ, DATA_W'($urandom));
    push_op(CMD_DEQ, DATA_W'($urandom));
    push_op(CMD_DEQ, DATA_W'($urandom));
    drain();

    // three slots: overflow, head advance, tail wrap forward and back from slot 0
    write_capacity(CAP_W'(3));
    push_op(CMD_ENQ, 1);
    push_op(CMD_ENQ, 3);
    push_op(CMD_ENQ, 2);
    push_op(CMD_ENQ, 4);
    push_op(CMD_DEQ, '1);
    push_op(CMD_ENQ, -7);
    push_op(CMD_DEQ, '0);
    push_op(CMD_DEQ, '1);
    push_op(CMD_DEQ, '0);
    drain();

    // capacity zero behaves as a single slot
    write_capacity('0);
    push_op(CMD_ENQ, 1);
    push_op(CMD_ENQ, 2);
    push_op(CMD_DEQ, '0);
    drain();

    // random phases over a spread of capacities
    for (p = 0; p < 8; p++) begin
      if (phase_cap[p] < 0) write_capacity(CAP_W'($urandom_range(1, DEPTH)));
      else write_capacity(CAP_W'(phase_cap[p]));
      idle_pct = (p == 4) ? 0 : 19;
      pct = 50;
      for (k = 0; k < phase_len[p]; k++) begin
        // bursts lean toward filling or draining the ring
        if (k % 16 == 0) begin
          case ($urandom_range(0, 3))
            0:       pct = 20;
            1:       pct = 50;
            2:       pct = 75;
            default: pct = 90;
          endcase
        end
        // full-size ring: fill to overflow, then deep scans on the way down
        if (p == 0) pct = (k < 180) ? 90 : 20;
        push_op(($urandom_range(0, 99) < pct) ? CMD_ENQ : CMD_DEQ, rand_value());
        // sender pauses until every owed result is back
        if (p == 3 && k == phase_len[p] / 2) drain();
      end
      // receiver holds off while the sender keeps offering
      if (p == 0) begin
        hold_go = 1'b1;
        while (!hold_over) @(posedge clk_i);
        hold_go = 1'b0;
      end
      drain();
    end
    idle_pct = 19;

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
